### hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the gap NACK generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that cond holds at every rising clock edge outside reset.
`define GNACK_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that cons holds whenever ante holds, outside reset.
`define GNACK_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define GNACK_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define GNACK_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/gnack_pkg.sv
// Package with the types, constants and helpers of the gap NACK generator.
`timescale 1ns / 1ps

package gnack_pkg;

   localparam int SEQ_W       = 16;
   localparam int MASK_W      = 16;
   localparam int BITS_W      = 4;   // enough to hold a shift of up to MASK_W-1
   // Entries of the command queue; must be a power of two.
   localparam int QUEUE_DEPTH = 2;

   // One gap to be reported, handed from the front end to the back end.
   typedef struct packed {
      logic [SEQ_W-1:0] start_seq;
      logic [SEQ_W-1:0] end_seq;
      logic             truncated;
   } gnack_cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE = 2'b01,
      BACK_RUN  = 2'b10
   } gnack_back_state_type;

   // True when a is strictly after b in 16-bit sequence space.
   function automatic logic seq_after(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return (d != '0) && !d[SEQ_W-1];
   endfunction

endpackage

### hdl/gnack_front.sv
// Front end: takes each received sequence number, detects gaps and queues them.
`timescale 1ns / 1ps

module gnack_front import gnack_pkg::*; #(
   parameter int MAX_NACK_ITEMS = 64,
   parameter int MASK_SPAN      = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [SEQ_W-1:0] req_seq_number,
   input  logic [SEQ_W-1:0] req_last_delivered_seq,
   input  logic             req_first_delivered,
   input  logic             req_congested,
   output logic             push_valid,
   input  logic             push_ready,
   output gnack_cmd_type    push_cmd
);

   localparam logic [SEQ_W-1:0] ItemLimit = SEQ_W'(MAX_NACK_ITEMS * MASK_SPAN);

   logic [SEQ_W-1:0] nack_mark_ff, nack_mark_in;
   logic [SEQ_W-1:0] delivered_mark, nacked_mark, start_seq, span_len;
   logic             accept, gap, suppress;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      delivered_mark = req_last_delivered_seq + SEQ_W'(1);
      nacked_mark    = nack_mark_ff + SEQ_W'(1);
      gap = req_first_delivered
         && seq_after(req_seq_number, delivered_mark)
         && seq_after(req_seq_number, nacked_mark);
      // The first missing number follows the later of the two marks.
      start_seq = seq_after(delivered_mark, nack_mark_ff) ? delivered_mark : nacked_mark;
      span_len  = req_seq_number - start_seq;
      // A congested gap is dropped entirely, including the mark update.
      suppress  = gap && req_congested;

      push_valid          = accept && gap && !req_congested;
      push_cmd.start_seq  = start_seq;
      push_cmd.end_seq    = req_seq_number;
      push_cmd.truncated  = span_len > ItemLimit;

      nack_mark_in = nack_mark_ff;
      if (accept && !suppress && seq_after(req_seq_number, nack_mark_ff)) begin
         nack_mark_in = req_seq_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nack_mark_ff <= '0;
      end else begin
         nack_mark_ff <= nack_mark_in;
      end
   end

endmodule

### hdl/gnack_queue.sv
// Small command queue between the front end and the back end.
`timescale 1ns / 1ps

module gnack_queue import gnack_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  gnack_cmd_type push_cmd,
   output logic          pop_valid,
   input  logic          pop_ready,
   output gnack_cmd_type pop_cmd
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   gnack_cmd_type entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = count_ff != (PtrW + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PtrW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/gnack_back.sv
// Back end: walks one queued gap, issuing its NACK transactions one per cycle unless the output stalls.
`timescale 1ns / 1ps

module gnack_back import gnack_pkg::*; #(
   parameter int MAX_NACK_ITEMS = 64,
   parameter int MASK_SPAN      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  gnack_cmd_type     pop_cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SEQ_W-1:0]  rsp_nack_pid,
   output logic [MASK_W-1:0] rsp_nack_mask,
   output logic              rsp_run_end,
   output logic              rsp_truncated
);

   localparam int CntW = (MAX_NACK_ITEMS > 1) ? $clog2(MAX_NACK_ITEMS) : 1;

   gnack_back_state_type state_ff, state_in;
   logic [SEQ_W-1:0]  pid_ff, pid_in, end_seq_ff;
   logic              trunc_ff;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEQ_W-1:0]  rsp_pid_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic              rsp_last_ff, rsp_trunc_ff;
   logic [SEQ_W-1:0]  remaining, rem_minus_one;
   logic [BITS_W-1:0] mask_bits;
   logic [MASK_W-1:0] mask;
   logic              last_item, emit, load;

   assign pop_ready = (state_ff == BACK_IDLE);
   assign load      = pop_valid && pop_ready;
   assign emit      = (state_ff == BACK_RUN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      remaining     = end_seq_ff - pid_ff;
      rem_minus_one = remaining - SEQ_W'(1);
      if (rem_minus_one > SEQ_W'(MASK_SPAN - 1)) begin
         mask_bits = BITS_W'(MASK_SPAN - 1);
      end else begin
         mask_bits = rem_minus_one[BITS_W-1:0];
      end
      mask = (MASK_W'(1) << mask_bits) - MASK_W'(1);
      last_item = (remaining <= SEQ_W'(MASK_SPAN)) || (cnt_ff == CntW'(MAX_NACK_ITEMS - 1));

      state_in = state_ff;
      pid_in   = pid_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (load) begin
               state_in = BACK_RUN;
               pid_in   = pop_cmd.start_seq;
               cnt_in   = '0;
            end
         end
         BACK_RUN: begin
            if (emit) begin
               pid_in = pid_ff + SEQ_W'(MASK_SPAN);
               cnt_in = cnt_ff + CntW'(1);
               if (last_item) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff <= pid_in;
      cnt_ff <= cnt_in;
      if (load) begin
         end_seq_ff <= pop_cmd.end_seq;
         trunc_ff   <= pop_cmd.truncated;
      end
      if (emit) begin
         rsp_pid_ff   <= pid_ff;
         rsp_mask_ff  <= mask;
         rsp_last_ff  <= last_item;
         rsp_trunc_ff <= trunc_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_nack_pid  = rsp_pid_ff;
   assign rsp_nack_mask = rsp_mask_ff;
   assign rsp_run_end   = rsp_last_ff;
   assign rsp_truncated = rsp_trunc_ff;

endmodule

### hdl/rtp_gap_nack_generator_core.sv
// Top level of the RTP gap NACK generator: front end, command queue and back end.
//
// For every received RTP sequence number this block checks, modulo 2^16, whether the
// number jumps past both the last delivered sequence and the last NACKed sequence. If
// it does, and congestion is not reported, it issues generic NACK transactions (a PID
// and a loss mask) covering every missing sequence from just after the later of the
// two marks up to, but not including, the received number, MASK_SPAN sequences per
// transaction. A run is capped at MAX_NACK_ITEMS transactions; every transaction of a
// capped run has truncated set, and the final one of any run has the run-end flag set.
// Timing: an input transaction is taken by the front end, which updates the last NACKed
// mark at once and places a gap command in a two-entry queue. The back end fetches a
// command in its idle state and then issues one NACK per cycle while the result channel
// is ready. While the back end is working, the front end keeps taking transactions until
// the queue is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtp_gap_nack_generator_core import gnack_pkg::*; #(
   parameter int MAX_NACK_ITEMS = 64,
   parameter int MASK_SPAN      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [SEQ_W-1:0]  req_seq_number,
   input  logic [SEQ_W-1:0]  req_last_delivered_seq,
   input  logic              req_first_delivered,
   input  logic              req_congested,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SEQ_W-1:0]  rsp_nack_pid,
   output logic [MASK_W-1:0] rsp_nack_mask,
   output logic              rsp_run_end,
   output logic              rsp_truncated
);

   // A full span sets every mask bit below MASK_SPAN-1.
   localparam logic [MASK_W-1:0] FullMask = MASK_W'((1 << (MASK_SPAN - 1)) - 1);

   logic          push_valid, push_ready, pop_valid, pop_ready;
   gnack_cmd_type push_cmd, pop_cmd;
   logic          mid_run, full_ok, mask_ok;

   // The front end owns the last NACKed mark, so the next packet is judged
   // against it even while earlier runs are still queued.
   gnack_front #(
      .MAX_NACK_ITEMS (MAX_NACK_ITEMS),
      .MASK_SPAN      (MASK_SPAN)
   ) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_seq_number         (req_seq_number),
      .req_last_delivered_seq (req_last_delivered_seq),
      .req_first_delivered    (req_first_delivered),
      .req_congested          (req_congested),
      .push_valid             (push_valid),
      .push_ready             (push_ready),
      .push_cmd               (push_cmd)
   );

   gnack_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   gnack_back #(
      .MAX_NACK_ITEMS (MAX_NACK_ITEMS),
      .MASK_SPAN      (MASK_SPAN)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_cmd       (pop_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_nack_pid  (rsp_nack_pid),
      .rsp_nack_mask (rsp_nack_mask),
      .rsp_run_end   (rsp_run_end),
      .rsp_truncated (rsp_truncated)
   );

   assign mid_run = rsp_valid && !rsp_run_end;
   assign full_ok = rsp_nack_mask == FullMask;
   assign mask_ok = (((rsp_nack_mask + MASK_W'(1)) & rsp_nack_mask) == '0)
                    && ((rsp_nack_mask & ~FullMask) == '0);

   // Every NACK before the final one of its run covers a whole span.
   `GNACK_ASSERT_IMPLIES(a_full_span, clock, reset, mid_run, full_ok, "partial mask mid-run")

   // The loss mask is always a run of ones starting at bit zero, within the span.
   `GNACK_ASSERT_IMPLIES(a_mask_shape, clock, reset, rsp_valid, mask_ok, "malformed NACK mask")

   // An empty queue is never reported as full.
   `GNACK_ASSERT_IMPLIES(a_queue_drain, clock, reset, !pop_valid, push_ready, "queue full while empty")

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the RTP gap NACK generator core.
`timescale 1ns / 1ps

module testbench import gnack_pkg::*; ();

   // The block is built with its default cap and span; the predictor uses the same values.
   localparam int MAX_NACK_ITEMS = 64;
   localparam int MASK_SPAN      = 16;

   // The slowest legal stretch without any accepted transaction is the long receiver
   // hold-off below, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PACKETS = 480;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 20;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [SEQ_W-1:0]  req_seq_number;
   logic [SEQ_W-1:0]  req_last_delivered_seq;
   logic              req_first_delivered;
   logic              req_congested;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [SEQ_W-1:0]  rsp_nack_pid;
   logic [MASK_W-1:0] rsp_nack_mask;
   logic              rsp_run_end;
   logic              rsp_truncated;

   // One generic NACK transaction as it appears on the result channel.
   typedef struct packed {
      logic [SEQ_W-1:0]  pid;
      logic [MASK_W-1:0] mask;
      logic              run_end;
      logic              trunc;
   } nack_item_type;

   // The scoreboard keeps its own copy of the last NACKed mark and predicts the
   // NACK transactions that each accepted packet causes.
   class nack_scoreboard;
      nack_item_type pending_nacks[$];
      logic [15:0]   nack_mark;
      int unsigned   failures;

      function new();
         nack_mark = '0;
         failures  = 0;
      endfunction

      // True when a lies strictly after b in the 16-bit sequence space.
      function bit is_later(logic [15:0] a, logic [15:0] b);
         logic [15:0] d;
         d = a - b;
         return (d != 16'd0) && (d < 16'h8000);
      endfunction

      function void note_packet(logic [15:0] seq, logic [15:0] delivered,
                                logic first, logic cong);
         logic [15:0]   start;
         logic [15:0]   gap_len;
         logic [15:0]   pid;
         logic [15:0]   offset;
         logic [15:0]   left;
         logic [31:0]   ones;
         int unsigned   span_count;
         int unsigned   emit;
         int unsigned   bits;
         bit            gap;
         bit            trunc;
         nack_item_type item;
         gap = first && is_later(seq, delivered + 16'd1) && is_later(seq, nack_mark + 16'd1);
         // A gap seen under congestion is dropped and the mark does not move.
         if (gap && cong)
            return;
         if (gap) begin
            // Reporting starts after whichever mark is later.
            start = delivered + 16'd1;
            if (!is_later(start, nack_mark))
               start = nack_mark + 16'd1;
            gap_len    = seq - start;
            span_count = (gap_len + MASK_SPAN - 1) / MASK_SPAN;
            trunc      = span_count > MAX_NACK_ITEMS;
            emit       = trunc ? MAX_NACK_ITEMS : span_count;
            for (int unsigned i = 0; i < emit; i++) begin
               offset = 16'(i * MASK_SPAN);
               pid    = start + offset;
               left   = seq - pid;
               bits   = 32'(left) - 32'd1;
               if (bits > MASK_SPAN - 1)
                  bits = MASK_SPAN - 1;
               ones         = (32'd1 << bits) - 32'd1;
               item.pid     = pid;
               item.mask    = ones[15:0];
               item.run_end = (i + 1 == emit);
               item.trunc   = trunc;
               pending_nacks.push_back(item);
            end
         end
         if (is_later(seq, nack_mark))
            nack_mark = seq;
      endfunction

      function void check_nack(nack_item_type got);
         nack_item_type want;
         if (pending_nacks.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected NACK: pid %h mask %h end %b trunc %b",
                        got.pid, got.mask, got.run_end, got.trunc);
            return;
         end
         want = pending_nacks.pop_front();
         if (got.pid !== want.pid || got.mask !== want.mask ||
             got.run_end !== want.run_end || got.trunc !== want.trunc) begin
            failures++;
            if (failures <= 10) begin
               $display("NACK mismatch: expected pid %h mask %h end %b trunc %b",
                        want.pid, want.mask, want.run_end, want.trunc);
               $display("               got      pid %h mask %h end %b trunc %b",
                        got.pid, got.mask, got.run_end, got.trunc);
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_nacks.size();
      endfunction
   endclass

   nack_scoreboard sb;
   int unsigned    packets_sent;
   logic           hold_rsp;

   rtp_gap_nack_generator_core #(
      .MAX_NACK_ITEMS(MAX_NACK_ITEMS),
      .MASK_SPAN     (MASK_SPAN)
   ) u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_seq_number        (req_seq_number),
      .req_last_delivered_seq(req_last_delivered_seq),
      .req_first_delivered   (req_first_delivered),
      .req_congested         (req_congested),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_nack_pid          (rsp_nack_pid),
      .rsp_nack_mask         (rsp_nack_mask),
      .rsp_run_end           (rsp_run_end),
      .rsp_truncated         (rsp_truncated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle lengths are mostly zero or short, with the occasional long pause.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // Offers one packet after an idle gap and returns at the edge that accepts it.
   // With no gap, valid simply stays high while the payload changes, so valid never
   // gets two assignments in one time step.
   task automatic send_packet(logic [15:0] seq, logic [15:0] delivered,
                              logic first, logic cong, int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_seq_number         <= seq;
      req_last_delivered_seq <= delivered;
      req_first_delivered    <= first;
      req_congested          <= cong;
      req_valid              <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_packet(seq, delivered, first, cong);
      packets_sent++;
   endtask

   // Stimulus: a directed list of the interesting cases, then a random stream that
   // follows the predicted mark so that most packets land near it and form real gaps.
   initial begin
      logic [15:0] base;
      logic [15:0] seq;
      logic [15:0] delivered;
      int unsigned r;
      int unsigned calm_items;
      sb                     = new();
      packets_sent           = 0;
      calm_items             = 0;
      reset                  <= 1'b1;
      req_valid              <= 1'b0;
      req_seq_number         <= '0;
      req_last_delivered_seq <= '0;
      req_first_delivered    <= 1'b0;
      req_congested          <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Before the first delivery nothing is reported, but the mark still advances.
      send_packet(16'd100, 16'd0, 1'b0, 1'b0, pick_gap());
      // In-order packet: no gap.
      send_packet(16'd101, 16'd100, 1'b1, 1'b0, pick_gap());
      // A single lost sequence.
      send_packet(16'd103, 16'd101, 1'b1, 1'b0, pick_gap());
      // Exactly one full span lost: a single transaction with a full mask.
      send_packet(16'd120, 16'd103, 1'b1, 1'b0, pick_gap());
      // One sequence more than a span: two transactions.
      send_packet(16'd138, 16'd120, 1'b1, 1'b0, pick_gap());
      // A gap under congestion reports nothing and keeps the mark.
      send_packet(16'd200, 16'd138, 1'b1, 1'b1, pick_gap());
      // Congestion without a gap has no effect.
      send_packet(16'd139, 16'd138, 1'b1, 1'b1, pick_gap());
      // The delivered mark lags the NACK mark, so reporting starts after the NACK mark.
      send_packet(16'd200, 16'd130, 1'b1, 1'b0, pick_gap());
      // A run of exactly the cap, not truncated.
      send_packet(16'd1225, 16'd199, 1'b1, 1'b0, pick_gap());
      // A run beyond the cap, truncated.
      send_packet(16'd2300, 16'd1225, 1'b1, 1'b0, pick_gap());
      // A late packet: no gap and no change of the mark.
      send_packet(16'd2290, 16'd2299, 1'b1, 1'b0, pick_gap());
      // More than half the sequence space away: counts as earlier.
      send_packet(16'hFFF0, 16'd2300, 1'b1, 1'b0, pick_gap());
      // Walk the mark around the sequence space towards the wrap point.
      send_packet(16'h7000, 16'h6FFF, 1'b1, 1'b0, pick_gap());
      send_packet(16'hE000, 16'hDFFF, 1'b1, 1'b0, pick_gap());
      send_packet(16'hFFF8, 16'hFFF7, 1'b1, 1'b0, pick_gap());
      // A gap that crosses the wrap from 0xFFFF to zero.
      send_packet(16'h0012, 16'hFFF9, 1'b1, 1'b0, pick_gap());
      // Delivered at the top of the range, received at zero: no gap.
      send_packet(16'h0000, 16'hFFFF, 1'b1, 1'b1, pick_gap());
      // Exactly half the space ahead is not after.
      send_packet(16'h8013, 16'h0012, 1'b1, 1'b0, pick_gap());
      send_packet(16'hFFFF, 16'h0000, 1'b0, 1'b0, pick_gap());
      // A jump before the first delivery only moves the mark.
      send_packet(16'h0100, 16'h0013, 1'b0, 1'b1, pick_gap());
      send_packet(16'h0005, 16'hFFFF, 1'b1, 1'b0, pick_gap());
      // Delivered one behind the mark, with a partial last span.
      send_packet(16'h0140, 16'h00FF, 1'b1, 1'b0, pick_gap());

      for (int n = 0; n < RANDOM_PACKETS; n++) begin
         base = sb.nack_mark;
         r    = $urandom_range(0, 99);
         if (r < 50)
            seq = base + 16'd1;
         else if (r < 78)
            seq = base + 16'($urandom_range(2, 40));
         else if (r < 85)
            seq = base + 16'($urandom_range(41, 300));
         else if (r < 87)
            seq = base + 16'($urandom_range(900, 1500));
         else if (r < 94)
            seq = 16'($urandom);
         else
            seq = base - 16'($urandom_range(0, 20));

         r = $urandom_range(0, 99);
         if (r < 75)
            delivered = base - 16'($urandom_range(0, 3));
         else if (r < 88)
            delivered = base + 16'($urandom_range(1, 24));
         else
            delivered = 16'($urandom);

         if (calm_items > 0)
            calm_items--;
         else if ($urandom_range(0, 99) < 3)
            calm_items = $urandom_range(15, 40);

         send_packet(seq, delivered, $urandom_range(0, 99) < 94,
                     $urandom_range(0, 99) < 15, calm_items > 0 ? 0 : pick_gap());
      end
      req_valid <= 1'b0;

      // Wait for every predicted NACK, then a little longer to catch strays.
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Result side: check each accepted NACK and then choose the next ready value.
   // Calm stretches keep ready high; the hold flag forces it low.
   initial begin
      int unsigned   stall_left;
      int unsigned   calm_left;
      nack_item_type got;
      stall_left = 0;
      calm_left  = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.pid     = rsp_nack_pid;
            got.mask    = rsp_nack_mask;
            got.run_end = rsp_run_end;
            got.trunc   = rsp_truncated;
            sb.check_nack(got);
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
            if ($urandom_range(0, 99) < 2)
               calm_left = $urandom_range(50, 150);
         end
      end
   end

   // Once the random stream is well under way, the receiver holds off for a long
   // stretch while packets keep coming, so the queue fills and req_ready drops.
   initial begin
      hold_rsp <= 1'b0;
      wait (packets_sent >= 200);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // The watchdog ends the run when no transaction moves on either channel for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

endmodule
